// ----- hw/rtl/svpwm_duty_calculator_assert.svh -----
// Assertion helpers for svpwm_duty_calculator, the file that checks itself.
`ifndef SVPWM_DUTY_CALCULATOR_ASSERT_SVH
`define SVPWM_DUTY_CALCULATOR_ASSERT_SVH

// Same-cycle implication, disabled while reset is low.
`define SVPWM_ASSERT_HOLDS(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, disabled while reset is low.
`define SVPWM_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ----- hw/rtl/svpwm_pkg.sv -----
package svpwm_pkg;

	// sign codes of the six sectors, counterclockwise from the alpha axis
	localparam logic [2:0] SECT1_CODE = 3'd5;
	localparam logic [2:0] SECT2_CODE = 3'd7;
	localparam logic [2:0] SECT3_CODE = 3'd6;
	localparam logic [2:0] SECT4_CODE = 3'd2;
	localparam logic [2:0] SECT5_CODE = 3'd0;
	localparam logic [2:0] SECT6_CODE = 3'd1;
	// code reported with a rejected vector
	localparam logic [2:0] CODE_NONE  = 3'd0;

	localparam int CFG_IDX_BITS = 2;
	localparam logic [CFG_IDX_BITS-1:0] CFG_VDC  = 2'd0;
	localparam logic [CFG_IDX_BITS-1:0] CFG_GAIN = 2'd1;

	localparam int VDC_BITS  = 15;
	localparam int GAIN_BITS = 32;
	localparam logic [VDC_BITS-1:0]  VDC_RESET  = 15'd16384;
	localparam logic [GAIN_BITS-1:0] GAIN_RESET = 32'd454047;

	// sqrt3/2 in Q0.24
	localparam logic [23:0] SQRT3_HALF_Q24 = 24'd14529495;
	// fraction bits of the scaled time terms
	localparam int FRAC_BITS = 40;

	typedef struct packed {
		logic [2:0] code;
		logic       reject;
	} tag_t;

endpackage

// ----- hw/rtl/svpwm_front.sv -----
module svpwm_front #(
	parameter int VOLT_BITS = 16
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              in_valid,
	output logic                              in_ready,
	input  logic signed [VOLT_BITS-1:0]       v_alpha,
	input  logic signed [VOLT_BITS-1:0]       v_beta,
	input  logic [svpwm_pkg::VDC_BITS-1:0]    vdc,
	output logic                              out_valid,
	input  logic                              out_ready,
	output svpwm_pkg::tag_t                   tag_o,
	output logic [2:0][VOLT_BITS+25:0]        mag_o,
	output logic [2:0]                        neg_o
);

	localparam int VB   = VOLT_BITS;
	localparam int SQW  = 2 * VB;
	localparam int KW   = VB + 25;
	localparam int TW   = VB + 26;
	localparam int VSQW = 2 * svpwm_pkg::VDC_BITS;
	localparam int CW   = (SQW + 2 > VSQW) ? SQW + 2 : VSQW;

	logic ld_s1, ld_s2;
	logic v_s1, v_s2;

	logic signed [VB-1:0]   a_s1, b_s1;
	logic [SQW-1:0]         aa_s1, bb_s1;
	logic [VSQW-1:0]        vsq_s1;
	logic signed [KW-1:0]   ka_s1;

	logic signed [SQW-1:0]  a_x, b_x, aa_c, bb_c;
	logic signed [KW-1:0]   ka_c;
	logic [VSQW-1:0]        vsq_c;

	assign ld_s2    = !v_s2 || out_ready;
	assign ld_s1    = !v_s1 || ld_s2;
	assign in_ready = ld_s1;

	// stage 1: squares and the sqrt3/2 product
	assign a_x   = SQW'(v_alpha);
	assign b_x   = SQW'(v_beta);
	assign aa_c  = a_x * a_x;
	assign bb_c  = b_x * b_x;
	assign ka_c  = KW'(v_alpha) * $signed({1'b0, svpwm_pkg::SQRT3_HALF_Q24});
	assign vsq_c = VSQW'(vdc) * VSQW'(vdc);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (ld_s1) begin
			v_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (ld_s1 && in_valid) begin
			a_s1   <= v_alpha;
			b_s1   <= v_beta;
			aa_s1  <= $unsigned(aa_c);
			bb_s1  <= $unsigned(bb_c);
			ka_s1  <= ka_c;
			vsq_s1 <= vsq_c;
		end
	end

	// stage 2: magnitude limit, sector code, time terms
	logic [CW-1:0]         msum;
	logic                  reject_c;
	logic [SQW+1:0]        aa3;
	logic                  a_neg, a_zero, b_neg, b_pos, lt3, gt3;
	logic                  above_pos, above_neg;
	logic signed [TW-1:0]  p_c, q_c, r_c, b23, b24;

	assign msum     = CW'(aa_s1) + CW'(bb_s1);
	assign reject_c = msum > CW'(vsq_s1);

	assign aa3    = {1'b0, aa_s1, 1'b0} + (SQW+2)'(aa_s1);
	assign a_neg  = a_s1[VB-1];
	assign a_zero = (a_s1 == '0);
	assign b_neg  = b_s1[VB-1];
	assign b_pos  = !b_neg && (b_s1 != '0);
	assign lt3    = (SQW+2)'(bb_s1) < aa3;
	assign gt3    = (SQW+2)'(bb_s1) > aa3;

	// beta above sqrt3*alpha, and beta above -sqrt3*alpha, tested on squares
	assign above_pos = a_zero ? b_pos : (a_neg ? (!b_neg || lt3) : (b_pos && gt3));
	assign above_neg = a_zero ? b_pos : (!a_neg ? (!b_neg || lt3) : (b_pos && gt3));

	assign b23 = TW'(b_s1) <<< 23;
	assign b24 = TW'(b_s1) <<< 24;
	assign p_c = TW'(ka_s1) - b23;
	assign q_c = TW'(ka_s1) + b23;
	assign r_c = b24;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else if (ld_s2) begin
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (ld_s2 && v_s1) begin
			tag_o.code   <= {b_pos, above_pos, above_neg};
			tag_o.reject <= reject_c;
			neg_o        <= {r_c[TW-1], q_c[TW-1], p_c[TW-1]};
			mag_o[0]     <= p_c[TW-1] ? $unsigned(-p_c) : $unsigned(p_c);
			mag_o[1]     <= q_c[TW-1] ? $unsigned(-q_c) : $unsigned(q_c);
			mag_o[2]     <= r_c[TW-1] ? $unsigned(-r_c) : $unsigned(r_c);
		end
	end

	assign out_valid = v_s2;

endmodule

// ----- hw/rtl/svpwm_scale.sv -----
module svpwm_scale #(
	parameter int VOLT_BITS = 16
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               in_valid,
	output logic                               in_ready,
	input  svpwm_pkg::tag_t                    tag_i,
	input  logic [2:0][VOLT_BITS+25:0]         mag_i,
	input  logic [2:0]                         neg_i,
	input  logic [svpwm_pkg::GAIN_BITS-1:0]    gain,
	output logic                               out_valid,
	input  logic                               out_ready,
	output svpwm_pkg::tag_t                    tag_o,
	output logic signed [2:0][VOLT_BITS+43:0]  g_o
);

	localparam int TW = VOLT_BITS + 26;
	localparam int PW = TW + 16;
	localparam int RW = TW + 17;
	localparam int GW = TW + 18;

	logic ld_s3, ld_s4;
	logic v_s3, v_s4;

	svpwm_pkg::tag_t   tag_s3;
	logic [2:0]        neg_s3;
	logic [2:0][PW-1:0] hi_s3;
	logic [2:0][TW:0]   rnd_s3;

	logic [2:0][PW-1:0] hi_c;
	logic [2:0][RW-1:0] lo_c;

	assign ld_s4    = !v_s4 || out_ready;
	assign ld_s3    = !v_s3 || ld_s4;
	assign in_ready = ld_s3;

	// stage 3: split gain products, round the low half
	always_comb begin
		for (int k = 0; k < 3; k++) begin
			hi_c[k] = PW'(mag_i[k]) * PW'(gain[31:16]);
			lo_c[k] = RW'(PW'(mag_i[k]) * PW'(gain[15:0])) + RW'(17'h08000);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s3 <= 1'b0;
		end else if (ld_s3) begin
			v_s3 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (ld_s3 && in_valid) begin
			tag_s3 <= tag_i;
			neg_s3 <= neg_i;
			for (int k = 0; k < 3; k++) begin
				hi_s3[k]  <= hi_c[k];
				rnd_s3[k] <= lo_c[k][RW-1:16];
			end
		end
	end

	// stage 4: combine halves, restore sign
	logic [2:0][RW-1:0]        sum_c;
	logic signed [2:0][GW-1:0] g_c;

	always_comb begin
		for (int k = 0; k < 3; k++) begin
			sum_c[k] = RW'(hi_s3[k]) + RW'(rnd_s3[k]);
			g_c[k]   = neg_s3[k] ? -$signed({1'b0, sum_c[k]}) : $signed({1'b0, sum_c[k]});
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s4 <= 1'b0;
		end else if (ld_s4) begin
			v_s4 <= v_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (ld_s4 && v_s3) begin
			tag_o <= tag_s3;
			g_o   <= g_c;
		end
	end

	assign out_valid = v_s4;

endmodule

// ----- hw/rtl/svpwm_duty.sv -----
module svpwm_duty #(
	parameter int VOLT_BITS = 16,
	parameter int DUTY_BITS = 16
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              in_valid,
	output logic                              in_ready,
	input  svpwm_pkg::tag_t                   tag_i,
	input  logic signed [2:0][VOLT_BITS+43:0] g_i,
	output logic                              out_valid,
	input  logic                              out_ready,
	output logic [DUTY_BITS-1:0]              duty_a,
	output logic [DUTY_BITS-1:0]              duty_b,
	output logic [DUTY_BITS-1:0]              duty_c,
	output logic [2:0]                        sector_code,
	output logic                              ok,
	output logic                              saturated
);

	localparam int GW = VOLT_BITS + 44;
	localparam int TW = GW + 1;
	localparam int DW = GW + 3;
	localparam int FB = svpwm_pkg::FRAC_BITS;
	localparam int SH = FB + 1 - DUTY_BITS;
	localparam int UW = DW + 1 - SH;
	localparam logic signed [DW-1:0] ONE_Q = {{(DW-FB-1){1'b0}}, 1'b1, {FB{1'b0}}};
	localparam logic [DW:0] RND = {{(DW+1-SH){1'b0}}, 1'b1, {(SH-1){1'b0}}};

	logic ld_s5, ld_s6, ld_s7;
	logic v_s5, v_s6, v_s7;

	assign ld_s7    = !v_s7 || out_ready;
	assign ld_s6    = !v_s6 || ld_s7;
	assign ld_s5    = !v_s5 || ld_s6;
	assign in_ready = ld_s5;

	// stage 5: pick the two active times of the sector
	logic signed [TW-1:0] gp, gq, gr, t1_c, t2_c;
	logic signed [TW-1:0] t1_s5, t2_s5;
	svpwm_pkg::tag_t      tag_s5;

	// an element of a packed array reads as unsigned, so sign it first
	assign gp = TW'($signed(g_i[0]));
	assign gq = TW'($signed(g_i[1]));
	assign gr = TW'($signed(g_i[2]));

	always_comb begin
		case (tag_i.code)
			svpwm_pkg::SECT1_CODE: begin t1_c = gp;  t2_c = gr;  end
			svpwm_pkg::SECT2_CODE: begin t1_c = gq;  t2_c = -gp; end
			svpwm_pkg::SECT3_CODE: begin t1_c = gr;  t2_c = -gq; end
			svpwm_pkg::SECT4_CODE: begin t1_c = -gp; t2_c = -gr; end
			svpwm_pkg::SECT5_CODE: begin t1_c = -gq; t2_c = gp;  end
			svpwm_pkg::SECT6_CODE: begin t1_c = -gr; t2_c = gq;  end
			default:               begin t1_c = '0;  t2_c = '0;  end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s5 <= 1'b0;
		end else if (ld_s5) begin
			v_s5 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (ld_s5 && in_valid) begin
			tag_s5 <= tag_i;
			t1_s5  <= t1_c;
			t2_s5  <= t2_c;
		end
	end

	// stage 6: twice each duty is one plus or minus each active time
	logic signed [DW-1:0] pp, pm, mp, mm;
	logic signed [DW-1:0] da_c, db_c, dc_c;
	logic signed [DW-1:0] da_s6, db_s6, dc_s6;
	svpwm_pkg::tag_t      tag_s6;

	assign pp = ONE_Q + DW'(t1_s5) + DW'(t2_s5);
	assign pm = ONE_Q + DW'(t1_s5) - DW'(t2_s5);
	assign mp = ONE_Q - DW'(t1_s5) + DW'(t2_s5);
	assign mm = ONE_Q - DW'(t1_s5) - DW'(t2_s5);

	always_comb begin
		case (tag_s5.code)
			svpwm_pkg::SECT1_CODE: begin da_c = pp; db_c = mp; dc_c = mm; end
			svpwm_pkg::SECT2_CODE: begin da_c = pm; db_c = pp; dc_c = mm; end
			svpwm_pkg::SECT3_CODE: begin da_c = mm; db_c = pp; dc_c = mp; end
			svpwm_pkg::SECT4_CODE: begin da_c = mm; db_c = pm; dc_c = pp; end
			svpwm_pkg::SECT5_CODE: begin da_c = mp; db_c = mm; dc_c = pp; end
			svpwm_pkg::SECT6_CODE: begin da_c = pp; db_c = mm; dc_c = pm; end
			default:               begin da_c = mm; db_c = mm; dc_c = mm; end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s6 <= 1'b0;
		end else if (ld_s6) begin
			v_s6 <= v_s5;
		end
	end

	always_ff @(posedge clk) begin
		if (ld_s6 && v_s5) begin
			tag_s6 <= tag_s5;
			da_s6  <= da_c;
			db_s6  <= db_c;
			dc_s6  <= dc_c;
		end
	end

	// stage 7: round to the output grid and clamp; top bit is the clamp flag
	function automatic logic [DUTY_BITS:0] to_duty(input logic signed [DW-1:0] d);
		logic [DW:0]   sum;
		logic [UW-1:0] u;
		logic          over;
		sum  = {1'b0, $unsigned(d)} + RND;
		u    = sum[DW:SH];
		over = |u[UW-1:DUTY_BITS];
		if (d[DW-1]) begin
			to_duty = {1'b1, {DUTY_BITS{1'b0}}};
		end else if (over) begin
			to_duty = {1'b1, {DUTY_BITS{1'b1}}};
		end else begin
			to_duty = {1'b0, u[DUTY_BITS-1:0]};
		end
	endfunction

	logic [DUTY_BITS:0] qa, qb, qc;

	assign qa = to_duty(da_s6);
	assign qb = to_duty(db_s6);
	assign qc = to_duty(dc_s6);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s7 <= 1'b0;
		end else if (ld_s7) begin
			v_s7 <= v_s6;
		end
	end

	always_ff @(posedge clk) begin
		if (ld_s7 && v_s6) begin
			if (tag_s6.reject) begin
				duty_a      <= '0;
				duty_b      <= '0;
				duty_c      <= '0;
				sector_code <= svpwm_pkg::CODE_NONE;
				ok          <= 1'b0;
				saturated   <= 1'b0;
			end else begin
				duty_a      <= qa[DUTY_BITS-1:0];
				duty_b      <= qb[DUTY_BITS-1:0];
				duty_c      <= qc[DUTY_BITS-1:0];
				sector_code <= tag_s6.code;
				ok          <= 1'b1;
				saturated   <= qa[DUTY_BITS] | qb[DUTY_BITS] | qc[DUTY_BITS];
			end
		end
	end

	assign out_valid = v_s7;

endmodule

// ----- hw/rtl/svpwm_duty_calculator.sv -----
// Seven-segment space-vector PWM duty calculator.
// Pipeline: seven register stages; out_valid rises when an accepted input
// word leaves the last of them. Throughput: one word per cycle; an output
// stall holds a stage only while every stage after it is full.
// Reset (arst_n low, asynchronous): all stages empty, vdc = 16384,
// duty_gain = 454047.
module svpwm_duty_calculator #(
	parameter int VOLT_BITS = 16,
	parameter int DUTY_BITS = 16
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	// input channel
	input  logic                                 in_valid,
	output logic                                 in_stall,
	input  logic signed [VOLT_BITS-1:0]          v_alpha,
	input  logic signed [VOLT_BITS-1:0]          v_beta,
	// output channel
	output logic                                 out_valid,
	input  logic                                 out_stall,
	output logic [DUTY_BITS-1:0]                 duty_a,
	output logic [DUTY_BITS-1:0]                 duty_b,
	output logic [DUTY_BITS-1:0]                 duty_c,
	output logic [2:0]                           sector_code,
	output logic                                 ok,
	output logic                                 saturated,
	// configuration writes
	input  logic                                 cfg_we,
	input  logic [svpwm_pkg::CFG_IDX_BITS-1:0]   cfg_index,
	input  logic [svpwm_pkg::GAIN_BITS-1:0]      cfg_data
);

	`include "svpwm_duty_calculator_assert.svh"

	localparam int TW = VOLT_BITS + 26;
	localparam int GW = VOLT_BITS + 44;

	// Configuration registers. The user must write them only while the
	// pipeline is empty (the block does not enforce this), so every stage
	// may read them directly. Drop writes to unknown indexes.
	logic [svpwm_pkg::VDC_BITS-1:0]  vdc_q;
	logic [svpwm_pkg::GAIN_BITS-1:0] duty_gain_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vdc_q       <= svpwm_pkg::VDC_RESET;
			duty_gain_q <= svpwm_pkg::GAIN_RESET;
		end else if (cfg_we) begin
			case (cfg_index)
				svpwm_pkg::CFG_VDC:  vdc_q       <= cfg_data[svpwm_pkg::VDC_BITS-1:0];
				svpwm_pkg::CFG_GAIN: duty_gain_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// Front end: squares, magnitude limit, sector code and the three
	// signed time terms (sqrt3/2*alpha -/+ beta/2, and beta) in Q.24.
	logic                      front_ready, front_valid, scale_ready;
	svpwm_pkg::tag_t           front_tag;
	logic [2:0][TW-1:0]        front_mag;
	logic [2:0]                front_neg;

	svpwm_front #(
		.VOLT_BITS (VOLT_BITS)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (front_ready),
		.v_alpha   (v_alpha),
		.v_beta    (v_beta),
		.vdc       (vdc_q),
		.out_valid (front_valid),
		.out_ready (scale_ready),
		.tag_o     (front_tag),
		.mag_o     (front_mag),
		.neg_o     (front_neg)
	);

	// Gain: each term times duty_gain (sqrt3/vdc at reset), rounded half away from zero to Q.40.
	logic                      scale_valid, duty_ready;
	svpwm_pkg::tag_t           scale_tag;
	logic signed [2:0][GW-1:0] scale_g;

	svpwm_scale #(
		.VOLT_BITS (VOLT_BITS)
	) u_scale (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (front_valid),
		.in_ready  (scale_ready),
		.tag_i     (front_tag),
		.mag_i     (front_mag),
		.neg_i     (front_neg),
		.gain      (duty_gain_q),
		.out_valid (scale_valid),
		.out_ready (duty_ready),
		.tag_o     (scale_tag),
		.g_o       (scale_g)
	);

	// Back end: sector selection of T1/T2, split of the zero time, and
	// rounding plus clamping into the output register.
	svpwm_duty #(
		.VOLT_BITS (VOLT_BITS),
		.DUTY_BITS (DUTY_BITS)
	) u_duty (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (scale_valid),
		.in_ready    (duty_ready),
		.tag_i       (scale_tag),
		.g_i         (scale_g),
		.out_valid   (out_valid),
		.out_ready   (!out_stall),
		.duty_a      (duty_a),
		.duty_b      (duty_b),
		.duty_c      (duty_c),
		.sector_code (sector_code),
		.ok          (ok),
		.saturated   (saturated)
	);

	// Hold the input only when the first stage cannot hand its word on.
	assign in_stall = !front_ready;

	// Shorthands for the checks below.
	logic rej_zero, code_ok, gain_we;

	assign rej_zero = duty_a == '0 && duty_b == '0 && duty_c == '0 && !saturated
		&& sector_code == svpwm_pkg::CODE_NONE;
	assign code_ok  = sector_code inside {svpwm_pkg::SECT1_CODE, svpwm_pkg::SECT2_CODE,
		svpwm_pkg::SECT3_CODE, svpwm_pkg::SECT4_CODE, svpwm_pkg::SECT5_CODE,
		svpwm_pkg::SECT6_CODE};
	assign gain_we  = cfg_we && cfg_index == svpwm_pkg::CFG_GAIN;

	// A rejected vector carries zero duties, no sector and no clamp flag.
	`SVPWM_ASSERT_HOLDS(a_reject_zero, clk, arst_n, out_valid && !ok, rej_zero, "rejected not zero")
	// An accepted vector always lands in one of the six sectors.
	`SVPWM_ASSERT_HOLDS(a_code_valid, clk, arst_n, out_valid && ok, code_ok, "bad sector code")
	// Back pressure only ever originates at the output.
	`SVPWM_ASSERT_HOLDS(a_stall_source, clk, arst_n, in_stall, out_stall, "stray input stall")
	// A gain write takes effect on the next cycle.
	`SVPWM_ASSERT_NEXT(a_gain_write, clk, arst_n, gain_we, duty_gain_q == $past(cfg_data), "lost")

endmodule

// ----- dv/svpwm_duty_calculator_test.sv -----
`timescale 1ns / 100ps

module svpwm_duty_calculator_test;

	localparam int VOLT_W = 16;
	localparam int DUTY_W = 16;
	localparam int CLK_PERIOD = 4;
	localparam int N_DIRECTED = 26;
	localparam int N_SETTINGS = 6;
	localparam int ITEMS_PER_PHASE = 86;
	localparam int IDX_W = svpwm_pkg::CFG_IDX_BITS;
	localparam int VDC_W = svpwm_pkg::VDC_BITS;
	localparam int GAIN_W = svpwm_pkg::GAIN_BITS;
	// index outside the register map; a write to it must change nothing
	localparam logic [IDX_W-1:0] CFG_UNMAPPED = 2'd3;

	// one result word as it leaves the block
	typedef struct packed {
		logic [DUTY_W-1:0] duty_a;
		logic [DUTY_W-1:0] duty_b;
		logic [DUTY_W-1:0] duty_c;
		logic [2:0]        sector_code;
		logic              ok;
		logic              saturated;
	} duty_word_t;

	// one row of the directed table; the duties are typed in only where obvious
	typedef struct {
		logic signed [VOLT_W-1:0] alpha;
		logic signed [VOLT_W-1:0] beta;
		bit                       typed;
		duty_word_t               want;
	} vector_row_t;

	localparam duty_word_t REJECTED_WORD = '{duty_a: '0, duty_b: '0, duty_c: '0,
		sector_code: svpwm_pkg::CODE_NONE, ok: 1'b0, saturated: 1'b0};
	// the zero vector puts every phase at one half
	localparam duty_word_t CENTERED_WORD = '{duty_a: 16'd32768, duty_b: 16'd32768,
		duty_c: 16'd32768, sector_code: svpwm_pkg::SECT5_CODE, ok: 1'b1, saturated: 1'b0};

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_stall;
	logic signed [VOLT_W-1:0] v_alpha = '0;
	logic signed [VOLT_W-1:0] v_beta = '0;
	logic out_valid;
	logic out_stall = 1'b0;
	logic [DUTY_W-1:0] duty_a;
	logic [DUTY_W-1:0] duty_b;
	logic [DUTY_W-1:0] duty_c;
	logic [2:0] sector_code;
	logic ok;
	logic saturated;
	logic cfg_we = 1'b0;
	logic [IDX_W-1:0] cfg_index = '0;
	logic [GAIN_W-1:0] cfg_data = '0;

	// copy of the two registers as the block should hold them
	logic [VDC_W-1:0] model_vdc = svpwm_pkg::VDC_RESET;
	logic [GAIN_W-1:0] model_gain = svpwm_pkg::GAIN_RESET;

	duty_word_t expected_duties[$];
	int error_count = 0;
	int send_idle_pct = 0;
	int recv_idle_pct = 0;

	vector_row_t directed_rows [N_DIRECTED] = '{
		'{16'sd0, 16'sd0, 1'b1, CENTERED_WORD},
		// corners and axis ends of the input range lie far outside the bus circle
		'{16'sh8000, 16'sh8000, 1'b1, REJECTED_WORD},
		'{16'sh7FFF, 16'sh7FFF, 1'b1, REJECTED_WORD},
		'{16'sh8000, 16'sd0, 1'b1, REJECTED_WORD},
		'{16'sd0, 16'sh8000, 1'b1, REJECTED_WORD},
		'{16'sd0, 16'sh7FFF, 1'b1, REJECTED_WORD},
		// one step past the magnitude limit
		'{16'sd16385, 16'sd0, 1'b1, REJECTED_WORD},
		'{16'sd0, -16'sd16385, 1'b1, REJECTED_WORD},
		// exactly on the limit: still accepted, heavily overmodulated
		'{16'sd16384, 16'sd0, 1'b0, '0},
		'{16'sd0, 16'sd16384, 1'b0, '0},
		'{-16'sd16384, 16'sd0, 1'b0, '0},
		'{16'sd0, -16'sd16384, 1'b0, '0},
		// middle of each of the six sectors
		'{16'sd8660, 16'sd5000, 1'b0, '0},
		'{16'sd0, 16'sd10000, 1'b0, '0},
		'{-16'sd8660, 16'sd5000, 1'b0, '0},
		'{-16'sd8660, -16'sd5000, 1'b0, '0},
		'{16'sd0, -16'sd10000, 1'b0, '0},
		'{16'sd8660, -16'sd5000, 1'b0, '0},
		// just off the sector borders at 60, 120, 240 and 300 degrees
		'{16'sd5000, 16'sd8660, 1'b0, '0},
		'{-16'sd5000, 16'sd8660, 1'b0, '0},
		'{-16'sd5000, -16'sd8660, 1'b0, '0},
		'{16'sd5000, -16'sd8660, 1'b0, '0},
		// inside the circle but beyond the hexagon: duties clamp
		'{16'sd16000, 16'sd0, 1'b0, '0},
		'{16'sd15000, 16'sd5000, 1'b0, '0},
		// smallest vectors, at 315 and 135 degrees
		'{16'sd1, -16'sd1, 1'b0, '0},
		'{-16'sd1, 16'sd1, 1'b0, '0}
	};

	svpwm_duty_calculator #(
		.VOLT_BITS(VOLT_W),
		.DUTY_BITS(DUTY_W)
	) i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.v_alpha(v_alpha),
		.v_beta(v_beta),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.duty_a(duty_a),
		.duty_b(duty_b),
		.duty_c(duty_c),
		.sector_code(sector_code),
		.ok(ok),
		.saturated(saturated),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	always #(CLK_PERIOD / 2) clk = ~clk;

	// true exactly when y > sqrt3 * x, decided on squares so no rounding enters
	function automatic bit beyond_sqrt3_line(longint y, longint x);
		if (x == 0)
			return y > 0;
		if (x < 0) begin
			if (y >= 0)
				return 1'b1;
			return y * y < 3 * x * x;
		end
		if (y <= 0)
			return 1'b0;
		return y * y > 3 * x * x;
	endfunction

	// Q.24 term times the Q0.32 gain, rounded half away from zero to Q.40;
	// split the gain in two halves so the products stay inside 64 bits
	function automatic longint scale_by_gain(longint term);
		longint unsigned mag;
		longint unsigned gain_hi;
		longint unsigned gain_lo;
		longint unsigned prod;
		mag = $unsigned((term < 0) ? -term : term);
		gain_hi = 64'(model_gain[31:16]);
		gain_lo = 64'(model_gain[15:0]);
		prod = mag * gain_hi + ((mag * gain_lo + 64'h8000) >> 16);
		return (term < 0) ? -longint'(prod) : longint'(prod);
	endfunction

	// twice the duty in Q.40 down to Q0.16, round half up; the top bit flags a clamp
	function automatic logic [DUTY_W:0] round_duty(longint twice);
		longint rounded;
		if (twice < 0)
			return {1'b1, {DUTY_W{1'b0}}};
		rounded = (twice + (longint'(1) <<< (svpwm_pkg::FRAC_BITS - DUTY_W)))
			>>> (svpwm_pkg::FRAC_BITS + 1 - DUTY_W);
		if (rounded > longint'((1 << DUTY_W) - 1))
			return {1'b1, {DUTY_W{1'b1}}};
		return {1'b0, rounded[DUTY_W-1:0]};
	endfunction

	// duties, sector and flags for one vector under the current registers
	function automatic duty_word_t predict_duties(logic signed [VOLT_W-1:0] va,
		logic signed [VOLT_W-1:0] vb);
		longint a, b, gp, gq, gr, t1, t2, z, da, db, dc;
		longint unsigned ma, mb, lim;
		logic [2:0] code;
		logic [DUTY_W:0] ra, rb, rc;
		duty_word_t w;
		a = va;
		b = vb;
		ma = $unsigned((a < 0) ? -a : a);
		mb = $unsigned((b < 0) ? -b : b);
		lim = 64'(model_vdc);
		if (ma * ma + mb * mb > lim * lim)
			return REJECTED_WORD;
		code = {b > 0, beyond_sqrt3_line(b, a), beyond_sqrt3_line(b, -a)};
		gp = scale_by_gain(longint'(svpwm_pkg::SQRT3_HALF_Q24) * a - (b <<< 23));
		gq = scale_by_gain(longint'(svpwm_pkg::SQRT3_HALF_Q24) * a + (b <<< 23));
		gr = scale_by_gain(b <<< 24);
		case (code)
			svpwm_pkg::SECT1_CODE: begin t1 = gp;  t2 = gr;  end
			svpwm_pkg::SECT2_CODE: begin t1 = gq;  t2 = -gp; end
			svpwm_pkg::SECT3_CODE: begin t1 = gr;  t2 = -gq; end
			svpwm_pkg::SECT4_CODE: begin t1 = -gp; t2 = -gr; end
			svpwm_pkg::SECT5_CODE: begin t1 = -gq; t2 = gp;  end
			svpwm_pkg::SECT6_CODE: begin t1 = -gr; t2 = gq;  end
			default: begin t1 = 0; t2 = 0; end
		endcase
		// twice the half zero time, so each end gets z/2
		z = (longint'(1) <<< svpwm_pkg::FRAC_BITS) - t1 - t2;
		case (code)
			svpwm_pkg::SECT1_CODE: begin da = z + 2 * (t1 + t2); db = z + 2 * t2; dc = z; end
			svpwm_pkg::SECT2_CODE: begin da = z + 2 * t1; db = z + 2 * (t1 + t2); dc = z; end
			svpwm_pkg::SECT3_CODE: begin da = z; db = z + 2 * (t1 + t2); dc = z + 2 * t2; end
			svpwm_pkg::SECT4_CODE: begin da = z; db = z + 2 * t1; dc = z + 2 * (t1 + t2); end
			svpwm_pkg::SECT5_CODE: begin da = z + 2 * t2; db = z; dc = z + 2 * (t1 + t2); end
			svpwm_pkg::SECT6_CODE: begin da = z + 2 * (t1 + t2); db = z; dc = z + 2 * t1; end
			default: begin da = z; db = z; dc = z; end
		endcase
		ra = round_duty(da);
		rb = round_duty(db);
		rc = round_duty(dc);
		w.duty_a = ra[DUTY_W-1:0];
		w.duty_b = rb[DUTY_W-1:0];
		w.duty_c = rc[DUTY_W-1:0];
		w.sector_code = code;
		w.ok = 1'b1;
		w.saturated = ra[DUTY_W] | rb[DUTY_W] | rc[DUTY_W];
		return w;
	endfunction

	// Offer one vector word, idling first at the current rate, and hold it
	// until accepted. Leave in_valid high: a drain or an idling next call lowers it,
	// so valid never gets two assignments in one step.
	task automatic send_vector(input logic signed [VOLT_W-1:0] alpha,
		input logic signed [VOLT_W-1:0] beta, input bit typed, input duty_word_t want);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		v_alpha <= alpha;
		v_beta <= beta;
		do @(posedge clk); while (in_stall);
		// registers only change while idle, so predict with the current copy
		expected_duties.push_back(typed ? want : predict_duties(alpha, beta));
	endtask

	// Drop valid and hold off until every expected word has come back.
	task automatic wait_for_drain();
		in_valid <= 1'b0;
		do @(posedge clk); while (expected_duties.size() != 0);
	endtask

	// Write one register for a single cycle and track it in the local copy.
	task automatic write_reg(input logic [IDX_W-1:0] idx,
		input logic [GAIN_W-1:0] data);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		@(posedge clk);
		cfg_we <= 1'b0;
		if (idx == svpwm_pkg::CFG_VDC)
			model_vdc = data[VDC_W-1:0];
		else if (idx == svpwm_pkg::CFG_GAIN)
			model_gain = data;
		@(posedge clk);
	endtask

	// Mostly vectors inside the bus circle (some of them small), the rest
	// anywhere in the input range so that rejections stay frequent.
	task automatic pick_vector(output logic signed [VOLT_W-1:0] alpha,
		output logic signed [VOLT_W-1:0] beta);
		int radius;
		int ai;
		int bi;
		if ($urandom_range(99) < 20) begin
			alpha = VOLT_W'($urandom);
			beta = VOLT_W'($urandom);
		end else begin
			radius = int'(model_vdc);
			if ($urandom_range(3) == 0)
				radius = int'($urandom_range(radius));
			do begin
				ai = int'($urandom_range(2 * radius)) - radius;
				bi = int'($urandom_range(2 * radius)) - radius;
			end while (longint'(ai) * ai + longint'(bi) * bi > longint'(radius) * radius);
			alpha = VOLT_W'(ai);
			beta = VOLT_W'(bi);
		end
	endtask

	// Receiver: stall at random at the current rate.
	always @(posedge clk) begin
		out_stall <= ($urandom_range(99) < recv_idle_pct);
	end

	// Compare each accepted result word with the oldest expectation.
	always @(posedge clk) begin
		duty_word_t got;
		duty_word_t want;
		if (arst_n && out_valid && !out_stall) begin
			got = '{duty_a: duty_a, duty_b: duty_b, duty_c: duty_c,
				sector_code: sector_code, ok: ok, saturated: saturated};
			if (expected_duties.size() == 0) begin
				error_count++;
				if (error_count <= 10)
					$display("%0t: unexpected word a=%0d b=%0d c=%0d sector=%0d ok=%0b sat=%0b",
						$realtime, got.duty_a, got.duty_b, got.duty_c, got.sector_code,
						got.ok, got.saturated);
			end else begin
				want = expected_duties.pop_front();
				if (got.duty_a !== want.duty_a || got.duty_b !== want.duty_b ||
					got.duty_c !== want.duty_c || got.sector_code !== want.sector_code ||
					got.ok !== want.ok || got.saturated !== want.saturated) begin
					error_count++;
					if (error_count <= 10)
						$display("%0t: exp a=%0d b=%0d c=%0d sector=%0d ok=%0b sat=%0b,",
							$realtime, want.duty_a, want.duty_b, want.duty_c,
							want.sector_code, want.ok, want.saturated,
							" got a=%0d b=%0d c=%0d sector=%0d ok=%0b sat=%0b",
							got.duty_a, got.duty_b, got.duty_c, got.sector_code,
							got.ok, got.saturated);
				end
			end
		end
	end

	// Stimulus: directed table, then random words over three idle patterns,
	// each sweeping the register settings.
	initial begin
		logic [VDC_W-1:0] vdc_set [N_SETTINGS];
		logic [GAIN_W-1:0] gain_set [N_SETTINGS];
		logic signed [VOLT_W-1:0] alpha;
		logic signed [VOLT_W-1:0] beta;
		logic [GAIN_W-1:0] raw_vdc;
		// reset values, consistent full bus, zero bus, saturating gain,
		// a small bus, then an inconsistent random pair
		vdc_set = '{svpwm_pkg::VDC_RESET, 15'd32767, 15'd0, 15'd32767, 15'd1000, 15'd0};
		gain_set = '{svpwm_pkg::GAIN_RESET, 32'd227030, 32'd0, 32'hFFFFFFFF, 32'd7439102,
			32'd0};
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		send_idle_pct = 17;
		recv_idle_pct = 48;
		for (int n = 0; n < N_DIRECTED; n++)
			send_vector(directed_rows[n].alpha, directed_rows[n].beta,
				directed_rows[n].typed, directed_rows[n].want);

		for (int mode = 0; mode < 3; mode++) begin
			send_idle_pct = (mode == 0) ? 17 : (mode == 1) ? 48 : 0;
			recv_idle_pct = (mode == 0) ? 48 : (mode == 1) ? 17 : 0;
			for (int s = 0; s < N_SETTINGS; s++) begin
				// registers move only with the pipeline empty
				wait_for_drain();
				if (s == N_SETTINGS - 1) begin
					// junk above the vdc field must be dropped
					raw_vdc = $urandom;
					write_reg(svpwm_pkg::CFG_VDC, raw_vdc);
					write_reg(svpwm_pkg::CFG_GAIN, $urandom);
				end else begin
					write_reg(svpwm_pkg::CFG_VDC, {{(GAIN_W - VDC_W){1'b0}}, vdc_set[s]});
					write_reg(svpwm_pkg::CFG_GAIN, gain_set[s]);
				end
				if (mode == 0 && s == 0)
					write_reg(CFG_UNMAPPED, $urandom);
				for (int k = 0; k < ITEMS_PER_PHASE; k++) begin
					pick_vector(alpha, beta);
					send_vector(alpha, beta, 1'b0, '0);
				end
			end
		end

		wait_for_drain();
		// let any stray word surface past the pipeline depth
		repeat (20) @(posedge clk);
		if (error_count == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

	// Watchdog: far beyond the slowest correct run.
	initial begin
		#2000000;
		$display("DONE: errors detected");
		$finish;
	end

endmodule
